// ----- rtl/gbts_pkg.sv -----
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared types and codes for the gap buffer text store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gbts_pkg;

  localparam int CAP_BYTES_DEF = 4096;

  localparam int OPC_W  = 2;
  localparam int POS_W  = 13;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 2;

  localparam logic [OPC_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OPC_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OPC_W-1:0] OP_DELETE = 2'd2;
  localparam logic [OPC_W-1:0] OP_READ   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BEYOND = 2'd2;

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] data_byte;
    logic [POS_W-1:0]  delete_len;
  } gbts_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic [POS_W-1:0]  doc_length;
    logic [STAT_W-1:0] status;
  } gbts_out_t;

endpackage : gbts_pkg

`default_nettype wire

// ----- rtl/gap_buffer_text_store_core.sv -----
// ----------------------------------------------------------------------------
// gap_buffer_text_store_core
// Gap buffer text store: clear, insert, delete and read on one byte memory.
// ----------------------------------------------------------------------------
// An operation with no gap move (typing at the cursor, reads, clear, rejected
// inserts) takes the transaction and looks up the memory, then updates the gap
// and loads the result register, which waits while an earlier result is held.
// An insert or delete away from the gap start first copies bytes across the
// gap and then drains the last write-back, as the copy
// loop reads one byte and writes back one byte per cycle. The result register
// lets the next transaction be taken while a result waits. A full buffer
// rejects an insert with status 1; an insert past the end gets status 2. Store
// contents are undefined after reset but only written bytes are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gap_buffer_text_store_core
  import gbts_pkg::*;
#(
  parameter int CAP_BYTES = CAP_BYTES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire gbts_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output gbts_out_t      out_data
);

  localparam int AW = $clog2(CAP_BYTES);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [BYTE_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [BYTE_W-1:0] mem_rdata;

  gbts_ctrl #(
    .CAP_BYTES (CAP_BYTES),
    .AW        (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  gbts_mem #(
    .DEPTH (CAP_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule : gap_buffer_text_store_core

`default_nettype wire

// ----- rtl/gbts_mem.sv -----
// ----------------------------------------------------------------------------
// gbts_mem
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbts_mem
  import gbts_pkg::*;
#(
  parameter int DEPTH = CAP_BYTES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [BYTE_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic      [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] store_r [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      store_r[waddr] <= wdata;
    end
    rdata_r <= store_r[raddr];
  end

  assign rdata = rdata_r;

endmodule : gbts_mem

`default_nettype wire

// ----- rtl/gbts_ctrl.sv -----
// ----------------------------------------------------------------------------
// gbts_ctrl
// Gap pointers, gap move sequencer and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gbts_ctrl
  import gbts_pkg::*;
#(
  parameter int CAP_BYTES = CAP_BYTES_DEF,
  parameter int AW        = $clog2(CAP_BYTES)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire gbts_in_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output gbts_out_t              out_data,
  output logic                   mem_we,
  output logic      [AW-1:0]     mem_waddr,
  output logic      [BYTE_W-1:0] mem_wdata,
  output logic      [AW-1:0]     mem_raddr,
  input  wire logic [BYTE_W-1:0] mem_rdata
);

  localparam int PW = $clog2(CAP_BYTES + 1);
  localparam int CW = ((PW > POS_W) ? PW : POS_W) + 1;
  localparam logic [PW-1:0] CAP_P = PW'(CAP_BYTES);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_MOVE   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [PW-1:0]     gs_r, gs_nxt;
  logic [PW-1:0]     ge_r, ge_nxt;
  logic [PW-1:0]     cnt_r, cnt_nxt;
  logic              right_r, right_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_addr_r, pend_addr_nxt;
  logic [OPC_W-1:0]  op_r, op_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [POS_W-1:0]  dlen_r, dlen_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [AW-1:0]     rd_addr_r, rd_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  gbts_out_t         out_r, out_nxt;

  logic [PW-1:0] len;
  logic [CW-1:0] len_x, pos_x, gap_x, raw_x, room_x, dlen_x, len_new_x;
  logic [PW-1:0] tgt, room, del_add, len_new;
  logic          beyond, full, edit, accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    len    = CAP_P - (ge_r - gs_r);
    len_x  = {{(CW-PW){1'b0}}, len};
    pos_x  = {{(CW-POS_W){1'b0}}, in_data.position};
    gap_x  = {{(CW-PW){1'b0}}, ge_r - gs_r};
    tgt    = (pos_x > len_x) ? len : pos_x[PW-1:0];
    beyond = (in_data.opcode == OP_INSERT) && (pos_x > len_x);
    full   = (in_data.opcode == OP_INSERT) && (gs_r == ge_r);
    edit   = ((in_data.opcode == OP_INSERT) && !beyond && !full) ||
             (in_data.opcode == OP_DELETE);
    // logical to physical: skip the gap when at or past its start
    raw_x  = (pos_x < {{(CW-PW){1'b0}}, gs_r}) ? pos_x : (pos_x + gap_x);
    room   = CAP_P - ge_r;
    room_x = {{(CW-PW){1'b0}}, room};
    dlen_x = {{(CW-POS_W){1'b0}}, dlen_r};
    del_add = (dlen_x > room_x) ? room : dlen_x[PW-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    gs_nxt        = gs_r;
    ge_nxt        = ge_r;
    cnt_nxt       = cnt_r;
    right_nxt     = right_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    op_nxt        = op_r;
    byte_nxt      = byte_r;
    dlen_nxt      = dlen_r;
    status_nxt    = status_r;
    rd_ok_nxt     = rd_ok_r;
    rd_addr_nxt   = rd_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    in_ready      = (state_r == S_IDLE);
    mem_raddr     = rd_addr_r;
    // the copy pipeline owns the write port while a read is in flight
    mem_we        = pend_r;
    mem_waddr     = pend_addr_r;
    mem_wdata     = mem_rdata;

    case (state_r)
      S_IDLE: begin
        mem_raddr = raw_x[AW-1:0];
        if (accept) begin
          op_nxt      = in_data.opcode;
          byte_nxt    = in_data.data_byte;
          dlen_nxt    = in_data.delete_len;
          rd_ok_nxt   = (in_data.opcode == OP_READ) && (pos_x < len_x);
          rd_addr_nxt = raw_x[AW-1:0];
          status_nxt  = beyond ? ST_BEYOND : (full ? ST_FULL : ST_OK);
          right_nxt   = tgt > gs_r;
          cnt_nxt     = (tgt > gs_r) ? (tgt - gs_r) : (gs_r - tgt);
          state_nxt   = (edit && (tgt != gs_r)) ? S_MOVE : S_FINISH;
        end
      end
      S_MOVE: begin
        if (cnt_r != '0) begin
          // one byte crosses the gap per cycle; written back in the following cycle
          pend_nxt = 1'b1;
          cnt_nxt  = cnt_r - 1'b1;
          if (right_r) begin
            mem_raddr     = ge_r[AW-1:0];
            pend_addr_nxt = gs_r[AW-1:0];
            gs_nxt        = gs_r + 1'b1;
            ge_nxt        = ge_r + 1'b1;
          end else begin
            mem_raddr     = AW'(gs_r - 1'b1);
            pend_addr_nxt = AW'(ge_r - 1'b1);
            gs_nxt        = gs_r - 1'b1;
            ge_nxt        = ge_r - 1'b1;
          end
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          case (op_r)
            OP_CLEAR: begin
              gs_nxt = '0;
              ge_nxt = CAP_P;
            end
            OP_INSERT: begin
              if (status_r == ST_OK) begin
                mem_we    = 1'b1;
                mem_waddr = gs_r[AW-1:0];
                mem_wdata = byte_r;
                gs_nxt    = gs_r + 1'b1;
              end
            end
            OP_DELETE: begin
              ge_nxt = ge_r + del_add;
            end
            default: begin
            end
          endcase
          out_valid_nxt     = 1'b1;
          out_nxt.read_byte = rd_ok_r ? mem_rdata : '0;
          out_nxt.status    = status_r;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    len_new            = CAP_P - (ge_nxt - gs_nxt);
    len_new_x          = {{(CW-PW){1'b0}}, len_new};
    if ((state_r == S_FINISH) && (!out_valid_r || out_ready)) begin
      out_nxt.doc_length = len_new_x[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gs_r        <= '0;
      ge_r        <= CAP_P;
      cnt_r       <= '0;
      right_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gs_r        <= gs_nxt;
      ge_r        <= ge_nxt;
      cnt_r       <= cnt_nxt;
      right_r     <= right_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    op_r        <= op_nxt;
    byte_r      <= byte_nxt;
    dlen_r      <= dlen_nxt;
    status_r    <= status_nxt;
    rd_ok_r     <= rd_ok_nxt;
    rd_addr_r   <= rd_addr_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule : gbts_ctrl

`default_nettype wire

// ----- verif/gap_buffer_text_store_checker.sv -----
// ----------------------------------------------------------------------------
// gap_buffer_text_store_checker
// Watches both channels of the gap buffer text store. It keeps its own copy of
// the document and gap, works out the result of each input transaction and
// compares it field by field with the results the block returns, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gap_buffer_text_store_checker
  import gbts_pkg::*;
#(
  parameter int CAP = CAP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  gbts_in_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  gbts_out_t   out_data,
  output int          fail_count,
  output int          pending,
  output int unsigned doc_len_now,
  output int          results_seen,
  output int          full_rejects,
  output int          beyond_rejects,
  output int          peak_len
);

  logic [7:0]  text_mem [CAP];
  int unsigned gap_lo;
  int unsigned gap_hi;
  gbts_out_t   expected_q [$];

  function automatic int unsigned doc_span();
    return CAP - (gap_hi - gap_lo);
  endfunction

  // Byte-at-a-time copy across the gap, like the block's own copy loop.
  function automatic void slide_gap(input int unsigned target);
    int unsigned dest;
    dest = (target > doc_span()) ? doc_span() : target;
    while (gap_lo < dest) begin
      text_mem[gap_lo] = text_mem[gap_hi];
      gap_lo++;
      gap_hi++;
    end
    while (gap_lo > dest) begin
      gap_lo--;
      gap_hi--;
      text_mem[gap_hi] = text_mem[gap_lo];
    end
  endfunction

  function automatic gbts_out_t apply_edit(input gbts_in_t t);
    gbts_out_t   r;
    int unsigned room;
    int unsigned raw;
    r = '0;
    case (t.opcode)
      OP_CLEAR: begin
        gap_lo = 0;
        gap_hi = CAP;
      end
      OP_INSERT: begin
        // beyond-end check takes priority over the full check
        if (t.position > doc_span()) begin
          r.status = ST_BEYOND;
          beyond_rejects++;
        end else if (gap_lo == gap_hi) begin
          r.status = ST_FULL;
          full_rejects++;
        end else begin
          slide_gap(t.position);
          text_mem[gap_lo] = t.data_byte;
          gap_lo++;
        end
      end
      OP_DELETE: begin
        slide_gap(t.position);
        room = CAP - gap_hi;
        gap_hi += (t.delete_len > room) ? room : t.delete_len;
      end
      OP_READ: begin
        if (t.position < doc_span()) begin
          raw = (t.position < gap_lo) ? t.position : t.position + (gap_hi - gap_lo);
          r.read_byte = text_mem[raw];
        end
      end
      default: ;
    endcase
    r.doc_length = POS_W'(doc_span());
    if (doc_span() > peak_len) peak_len = doc_span();
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < 100)
      $display("MISMATCH at %0t ns: %s got %0d, wanted %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    gbts_out_t want;
    if (!rst_n) begin
      gap_lo = 0;
      gap_hi = CAP;
      expected_q.delete();
      fail_count = 0;
      results_seen = 0;
      full_rejects = 0;
      beyond_rejects = 0;
      peak_len = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, doc_length", int'(out_data.doc_length), -1);
        end else begin
          want = expected_q.pop_front();
          if (out_data.read_byte !== want.read_byte)
            report_mismatch("read_byte", int'(out_data.read_byte), int'(want.read_byte));
          if (out_data.doc_length !== want.doc_length)
            report_mismatch("doc_length", int'(out_data.doc_length), int'(want.doc_length));
          if (out_data.status !== want.status)
            report_mismatch("status", int'(out_data.status), int'(want.status));
        end
      end
      if (in_valid && in_ready)
        expected_q.push_back(apply_edit(in_data));
    end
    pending     <= expected_q.size();
    doc_len_now <= doc_span();
  end

endmodule

// ----- verif/gap_buffer_text_store_core_test.sv -----
// ----------------------------------------------------------------------------
// gap_buffer_text_store_core_test
// Stimulus for the gap buffer text store: a directed set of edge cases, then
// random editing sessions under three handshake regimes. Checking is done by
// gap_buffer_text_store_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gap_buffer_text_store_core_test;
  import gbts_pkg::*;

  localparam int CAP              = CAP_BYTES_DEF;
  localparam int STALL_LIMIT      = 40000;
  localparam int RANDOM_PER_PHASE = 376;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  gbts_in_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  gbts_out_t   out_data;

  int          send_idle = 0;
  int          recv_idle = 0;
  int          quiet_cycles = 0;

  int          fail_count;
  int          pending;
  int unsigned doc_len_now;
  int          results_seen;
  int          full_rejects;
  int          beyond_rejects;
  int          peak_len;

  always #6 clk = ~clk;

  gap_buffer_text_store_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  gap_buffer_text_store_checker #(.CAP(CAP)) mon (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .doc_len_now    (doc_len_now),
    .results_seen   (results_seen),
    .full_rejects   (full_rejects),
    .beyond_rejects (beyond_rejects),
    .peak_len       (peak_len)
  );

  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  // Watchdog: ends the run if no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic gbts_in_t pack_edit(input logic [OPC_W-1:0] opc, input int unsigned pos,
                                         input logic [BYTE_W-1:0] b, input int unsigned dl);
    gbts_in_t r;
    r.opcode     = opc;
    r.position   = pos[POS_W-1:0];
    r.data_byte  = b;
    r.delete_len = dl[POS_W-1:0];
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_edit(input gbts_in_t item);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_directed();
    push_edit(pack_edit(OP_READ,   0,    8'h3C, 0));     // read of empty document
    push_edit(pack_edit(OP_DELETE, 0,    8'h00, 8191));  // delete on empty document
    push_edit(pack_edit(OP_INSERT, 1,    8'h11, 0));     // insert past end
    push_edit(pack_edit(OP_INSERT, 8191, 8'hFF, 8191));
    push_edit(pack_edit(OP_INSERT, 0,    8'h00, 0));
    push_edit(pack_edit(OP_INSERT, 1,    8'hFF, 0));
    push_edit(pack_edit(OP_INSERT, 0,    8'hA5, 0));     // at the front, gap moves back
    push_edit(pack_edit(OP_INSERT, 2,    8'h5A, 0));     // middle, gap moves forward
    for (int i = 0; i < 5; i++) push_edit(pack_edit(OP_READ, i, 8'h00, 0));
    push_edit(pack_edit(OP_READ,   8191, 8'hFF, 8191));
    push_edit(pack_edit(OP_DELETE, 1,    8'h00, 1));
    push_edit(pack_edit(OP_DELETE, 8191, 8'h00, 5));     // beyond end removes nothing
    push_edit(pack_edit(OP_DELETE, 0,    8'h00, 0));
    push_edit(pack_edit(OP_READ,   1,    8'h00, 0));
    push_edit(pack_edit(OP_DELETE, 1,    8'h00, 8191));  // run longer than the tail
    push_edit(pack_edit(OP_READ,   0,    8'h00, 0));
    push_edit(pack_edit(OP_CLEAR,  8191, 8'hFF, 8191));
    push_edit(pack_edit(OP_READ,   0,    8'h00, 0));
  endtask

  // Editing session: typing at a cursor, scattered edits and reads, some noise.
  task automatic run_random(input int count);
    int unsigned len;
    int unsigned cursor;
    int unsigned pick;
    int unsigned pos;
    cursor = 0;
    repeat (count) begin
      len  = doc_len_now;
      if (cursor > len) cursor = len;
      pick = $urandom_range(99);
      if (pick < 2) begin
        push_edit(pack_edit(OP_CLEAR, $urandom_range(8191), BYTE_W'($urandom),
                            $urandom_range(8191)));
        cursor = 0;
      end else if (pick < 40) begin
        if (len >= 400) begin
          pos = $urandom_range(len);
          push_edit(pack_edit(OP_DELETE, pos, BYTE_W'($urandom), $urandom_range(64)));
          cursor = pos;
        end else begin
          push_edit(pack_edit(OP_INSERT, cursor, BYTE_W'($urandom), $urandom_range(8191)));
          cursor++;
        end
      end else if (pick < 50) begin
        pos = $urandom_range(len);
        push_edit(pack_edit(OP_INSERT, pos, BYTE_W'($urandom), $urandom_range(8191)));
        cursor = pos + 1;
      end else if (pick < 62) begin
        pos = $urandom_range(len);
        push_edit(pack_edit(OP_DELETE, pos, BYTE_W'($urandom), $urandom_range(16)));
        cursor = pos;
      end else if (pick < 90) begin
        push_edit(pack_edit(OP_READ, $urandom_range(len), BYTE_W'($urandom),
                            $urandom_range(8191)));
      end else begin
        push_edit(pack_edit(OPC_W'($urandom_range(3)), $urandom_range(8191),
                            BYTE_W'($urandom), $urandom_range(8191)));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 14; recv_idle = 81; end
        1: begin send_idle = 81; recv_idle = 14; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (phase == 0) run_directed();
      run_random(RANDOM_PER_PHASE);
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Checked %0d results: %0d full-buffer rejects, %0d beyond-end rejects",
             results_seen, full_rejects, beyond_rejects);
    $display("Peak document length %0d of %0d bytes; slow-receiver, slow-sender, back-to-back",
             peak_len, CAP);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
